// File: design/poly_evaluate_defines.svh
// Assertion macros shared by the poly_evaluate RTL.
// Each macro samples on clk; the first one is masked while rst is high.
`ifndef POLY_EVALUATE_DEFINES_SVH
`define POLY_EVALUATE_DEFINES_SVH

// Check a property outside of reset.
`define PE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included.
`define PE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/pe_pkg.sv
// Shared types and constants for the poly_evaluate pipeline.
// Used by every module of the block; depends on nothing.
package pe_pkg;

  localparam int COEF_REGS          = 8;
  localparam int DEFAULT_NUM_COEFFS = 8;
  localparam int Q_W                = 32;
  localparam int Q_FRAC             = 16;
  localparam int PROD_W             = 2 * Q_W;
  localparam int CFG_INDEX_W        = 4;

  typedef logic signed [Q_W-1:0] pe_q_t;

  localparam pe_q_t Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam pe_q_t Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  // Horner accumulator on its way between steps.
  typedef struct packed {
    pe_q_t acc;
    pe_q_t x;
    logic  ovf;
  } pe_item_t;

  // Full-width product of one step, before rounding.
  typedef struct packed {
    logic signed [PROD_W-1:0] prod;
    pe_q_t                    x;
    logic                     ovf;
  } pe_prod_t;

endpackage

// File: design/poly_evaluate.sv
// Top level of the polynomial evaluator: coefficient registers, a chain of
// Horner steps (multiply stage, round/add/saturate stage) and an output register.
// Depends on pe_pkg, pe_coef_regs, pe_mul_stage, pe_acc_stage, poly_evaluate_defines.svh.
`include "poly_evaluate_defines.svh"

// poly_evaluate computes, for each x_value beat, the polynomial
// coef_0 + coef_1*x + ... in signed Q16.16 by Horner's rule, starting from
// coef_{NUM_COEFFS-1}. Each step rounds the product to nearest (ties toward
// +inf), adds the next coefficient and saturates; m_tuser reports whether any
// step saturated. One beat is accepted per cycle unless the pipeline stalls.
// Between an accepted input beat and its result on the master side lie, for
// every Horner step, a multiply register and a round/add register, and then
// one output register. Each stage stalls only when it and everything
// downstream are full, so bubbles are squeezed out while m_tready is low.
// Coefficients are written through cfg_valid/cfg_index/cfg_data, which is
// always ready; write them only while no beat is in flight. Indexes at or
// above NUM_COEFFS are ignored.
module poly_evaluate #(
  parameter int NUM_COEFFS = pe_pkg::DEFAULT_NUM_COEFFS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [pe_pkg::Q_W-1:0]         s_tdata,   // [31:0] x_value
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [pe_pkg::Q_W-1:0]         m_tdata,   // [31:0] poly_value
  output logic [0:0]                     m_tuser,   // [0] overflow
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pe_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pe_pkg::Q_W-1:0]         cfg_data
);
  import pe_pkg::*;

  localparam int NUM_STEPS = NUM_COEFFS - 1;

  pe_q_t    coef        [NUM_COEFFS];
  pe_item_t item_chain  [NUM_STEPS+1];
  logic     chain_valid [NUM_STEPS+1];
  logic     chain_ready [NUM_STEPS+1];
  pe_item_t out_item;
  logic     out_valid;

  pe_coef_regs #(
    .NUM_COEFFS (NUM_COEFFS)
  ) u_coef_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  // Seed the accumulator with the highest active coefficient.
  assign item_chain[0].acc = coef[NUM_COEFFS-1];
  assign item_chain[0].x   = pe_q_t'(s_tdata);
  assign item_chain[0].ovf = 1'b0;
  assign chain_valid[0]    = s_tvalid;
  assign s_tready          = chain_ready[0];

  for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
    pe_prod_t prod;
    logic     prod_valid;
    logic     prod_ready;

    pe_mul_stage u_mul (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[k]),
      .in_ready  (chain_ready[k]),
      .in_item   (item_chain[k]),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_prod  (prod)
    );

    pe_acc_stage u_acc (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .in_prod   (prod),
      .coef      (coef[NUM_COEFFS-2-k]),
      .out_valid (chain_valid[k+1]),
      .out_ready (chain_ready[k+1]),
      .out_item  (item_chain[k+1])
    );
  end

  assign chain_ready[NUM_STEPS] = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (chain_ready[NUM_STEPS]) begin
      out_valid <= chain_valid[NUM_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (chain_ready[NUM_STEPS] && chain_valid[NUM_STEPS]) begin
      out_item <= item_chain[NUM_STEPS];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_item.acc;
  assign m_tuser  = out_item.ovf;

  `PE_ASSERT_ALWAYS(a_reset_clears_out, rst |=> !m_tvalid, "result valid right after reset")
  `PE_ASSERT(a_stall_only_when_full, !s_tready |-> (m_tvalid && !m_tready), "input stalled while output side can move")
  `PE_ASSERT(a_cfg_always_ready, cfg_valid |-> cfg_ready, "configuration write refused")

endmodule

// File: design/pe_coef_regs.sv
// Coefficient register file written through the configuration channel.
// Depends on pe_pkg.
module pe_coef_regs #(
  parameter int NUM_COEFFS = pe_pkg::DEFAULT_NUM_COEFFS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pe_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pe_pkg::Q_W-1:0]           cfg_data,
  output pe_pkg::pe_q_t                    coef [NUM_COEFFS]
);
  import pe_pkg::*;

  assign cfg_ready = 1'b1;

  // Registers past the active count are never read: drop those writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COEFFS; i++) begin
        coef[i] <= '0;
      end
    end else if (cfg_valid) begin
      for (int i = 0; i < NUM_COEFFS; i++) begin
        if (cfg_index == CFG_INDEX_W'(i)) begin
          coef[i] <= pe_q_t'(cfg_data);
        end
      end
    end
  end

endmodule

// File: design/pe_mul_stage.sv
// First half of a Horner step: registered signed product acc * x.
// Depends on pe_pkg.
module pe_mul_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  pe_pkg::pe_item_t in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output pe_pkg::pe_prod_t out_prod
);
  import pe_pkg::*;

  logic signed [PROD_W-1:0] prod_full;

  assign prod_full = in_item.acc * in_item.x;
  assign in_ready  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_prod.prod <= prod_full;
      out_prod.x    <= in_item.x;
      out_prod.ovf  <= in_item.ovf;
    end
  end

endmodule

// File: design/pe_acc_stage.sv
// Second half of a Horner step: round the product to Q16.16, add the
// coefficient and saturate. Depends on pe_pkg and poly_evaluate_defines.svh.
`include "poly_evaluate_defines.svh"

module pe_acc_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  pe_pkg::pe_prod_t in_prod,
  input  pe_pkg::pe_q_t    coef,
  output logic             out_valid,
  input  logic             out_ready,
  output pe_pkg::pe_item_t out_item
);
  import pe_pkg::*;

  localparam int Q_EXT_W = PROD_W - Q_FRAC;
  localparam int SUM_W   = Q_EXT_W + 1;
  localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(1) << (Q_FRAC - 1);

  logic signed [PROD_W-1:0]  rounded;
  logic signed [Q_EXT_W-1:0] q;
  logic signed [SUM_W-1:0]   sum;
  logic                      clamp_hi;
  logic                      clamp_lo;
  pe_item_t                  item_next;

  // Add half an LSB, then floor-shift: round to nearest, ties toward +inf.
  assign rounded = in_prod.prod + HALF_LSB;
  assign q       = rounded[PROD_W-1:Q_FRAC];
  assign sum     = {q[Q_EXT_W-1], q} + {{(SUM_W-Q_W){coef[Q_W-1]}}, coef};

  // Out of range when the bits above the result sign disagree with it.
  assign clamp_hi = !sum[SUM_W-1] && (|sum[SUM_W-2:Q_W-1]);
  assign clamp_lo = sum[SUM_W-1] && !(&sum[SUM_W-2:Q_W-1]);

  always_comb begin
    item_next.x   = in_prod.x;
    item_next.ovf = in_prod.ovf || clamp_hi || clamp_lo;
    if (clamp_hi) begin
      item_next.acc = Q_MAX;
    end else if (clamp_lo) begin
      item_next.acc = Q_MIN;
    end else begin
      item_next.acc = pe_q_t'(sum[Q_W-1:0]);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

  `PE_ASSERT(a_ovf_sticky, (in_valid && in_ready && in_prod.ovf) |=> out_item.ovf, "overflow flag lost between steps")
  `PE_ASSERT(a_clamp_flags, (in_valid && in_ready && (clamp_hi || clamp_lo)) |=> (out_item.ovf && (out_item.acc == Q_MAX || out_item.acc == Q_MIN)), "saturated step without flag or limit value")

endmodule
